// File: sv/sbus_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the SBUS frame decoder.
// No dependencies; used by sbus_frame_decoder and its testbench.
package sbus_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned PayloadLen = 22;
  localparam int unsigned PayloadAw  = $clog2(PayloadLen);
  localparam int unsigned FrameLen   = 25;
  localparam int unsigned PosW       = 5;
  localparam int unsigned ChanW      = 4;
  localparam int unsigned ChanBits   = 11;
  localparam int unsigned AccW       = ChanBits + ByteW - 1;
  localparam int unsigned CntW       = 5;

  localparam logic [ByteW-1:0] StartByte = 8'h0F;
  localparam logic [ByteW-1:0] EndByte   = 8'h00;

  localparam logic [PosW-1:0] PosHunt  = 5'd0;
  localparam logic [PosW-1:0] PosFirst = 5'd1;
  localparam logic [PosW-1:0] PosLastPayload = 5'd22;
  localparam logic [PosW-1:0] PosFlags = 5'd23;
  localparam logic [PosW-1:0] PosEnd   = 5'd24;
  localparam logic [PosW-1:0] PosLimit = 5'd25;

  localparam logic [ChanW-1:0] LastChan = 4'd15;

  typedef enum logic [1:0] {
    StRun,
    StRead,
    StLoad,
    StEmit
  } state_e;

endpackage

// File: sv/sbus_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sbus_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 22
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/sbus_frame_decoder.sv
`timescale 1ns / 1ps
// SBUS frame decoder top level: byte framing, payload store and serial unpacker.
// Depends on sbus_pkg and sbus_ram.
// Bytes are taken one per cycle while framing. After a good end byte the
// sequencer alternates a read state and a load state per payload byte from one
// RAM read port into an 18-bit shift accumulator, and an emit state registers
// each channel word, waiting while the output stalls. No byte is taken
// during unpacking. Reset clears the framing position, sequencer and output valid.
module sbus_frame_decoder (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [sbus_pkg::ByteW-1:0] rx_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [3:0]                 channel_o,
  output logic [10:0]                position_o,
  output logic                       last_o
);

  sbus_pkg::state_e state_q, state_d;

  logic [sbus_pkg::PosW-1:0]      pos_q, pos_d;
  logic [sbus_pkg::PayloadAw-1:0] rd_addr_q, rd_addr_d;
  logic [sbus_pkg::AccW-1:0]      acc_q, acc_d;
  logic [sbus_pkg::CntW-1:0]      cnt_q, cnt_d;
  logic [sbus_pkg::ChanW-1:0]     chan_q, chan_d;

  logic        out_valid_q, out_valid_d;
  logic [3:0]  channel_q, channel_d;
  logic [10:0] position_q, position_d;
  logic        last_q, last_d;

  logic                           in_go;
  logic                           emit_go;
  logic                           ram_we;
  logic [sbus_pkg::PayloadAw-1:0] ram_waddr;
  logic [sbus_pkg::ByteW-1:0]     ram_rdata;

  sbus_ram #(
    .Width(sbus_pkg::ByteW),
    .Depth(sbus_pkg::PayloadLen)
  ) u_payload_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(rx_byte_i),
    .raddr_i(rd_addr_q),
    .rdata_o(ram_rdata)
  );

  assign in_ready_o = (state_q == sbus_pkg::StRun);
  assign in_go      = in_valid_i && in_ready_o;
  assign emit_go    = (state_q == sbus_pkg::StEmit) && (!out_valid_q || out_ready_i);
  assign ram_waddr  = sbus_pkg::PayloadAw'(pos_q - sbus_pkg::PosFirst);

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    rd_addr_d   = rd_addr_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    chan_d      = chan_q;
    ram_we      = 1'b0;
    out_valid_d = out_valid_q;
    channel_d   = channel_q;
    position_d  = position_q;
    last_d      = last_q;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      sbus_pkg::StRun: begin
        if (in_go) begin
          if (pos_q == sbus_pkg::PosHunt || pos_q >= sbus_pkg::PosLimit) begin
            pos_d = (rx_byte_i == sbus_pkg::StartByte) ? sbus_pkg::PosFirst
                                                       : sbus_pkg::PosHunt;
          end else if (pos_q <= sbus_pkg::PosLastPayload) begin
            ram_we = 1'b1;
            pos_d  = pos_q + 5'd1;
          end else if (pos_q == sbus_pkg::PosFlags) begin
            pos_d = sbus_pkg::PosEnd;
          end else begin
            pos_d = sbus_pkg::PosHunt;
            if (rx_byte_i == sbus_pkg::EndByte) begin
              state_d   = sbus_pkg::StRead;
              rd_addr_d = '0;
              acc_d     = '0;
              cnt_d     = '0;
              chan_d    = '0;
            end
          end
        end
      end
      sbus_pkg::StRead: begin
        state_d = sbus_pkg::StLoad;
      end
      sbus_pkg::StLoad: begin
        acc_d     = acc_q | (sbus_pkg::AccW'(ram_rdata) << cnt_q);
        cnt_d     = cnt_q + 5'd8;
        rd_addr_d = rd_addr_q + 1'b1;
        state_d   = (cnt_d >= 5'd11) ? sbus_pkg::StEmit : sbus_pkg::StRead;
      end
      sbus_pkg::StEmit: begin
        if (emit_go) begin
          out_valid_d = 1'b1;
          channel_d   = chan_q;
          position_d  = acc_q[10:0];
          last_d      = (chan_q == sbus_pkg::LastChan);
          acc_d       = acc_q >> sbus_pkg::ChanBits;
          cnt_d       = cnt_q - 5'd11;
          chan_d      = chan_q + 1'b1;
          if (chan_q == sbus_pkg::LastChan) begin
            state_d = sbus_pkg::StRun;
          end else begin
            state_d = (cnt_d >= 5'd11) ? sbus_pkg::StEmit : sbus_pkg::StRead;
          end
        end
      end
      default: begin
        state_d = sbus_pkg::StRun;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sbus_pkg::StRun;
      pos_q       <= sbus_pkg::PosHunt;
      rd_addr_q   <= '0;
      cnt_q       <= '0;
      chan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      rd_addr_q   <= rd_addr_d;
      cnt_q       <= cnt_d;
      chan_q      <= chan_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    channel_q  <= channel_d;
    position_q <= position_d;
    last_q     <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign channel_o   = channel_q;
  assign position_o  = position_q;
  assign last_o      = last_q;

  // The payload holds exactly sixteen words, so reads never run past its end.
  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sbus_pkg::StLoad |-> rd_addr_q < sbus_pkg::PayloadAw'(sbus_pkg::PayloadLen))
    else $error("payload read beyond the stored frame");

  a_emit_has_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sbus_pkg::StEmit |-> cnt_q >= 5'd11)
    else $error("word emitted with too few accumulated bits");

  a_last_ends_unpack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_go && chan_q == sbus_pkg::LastChan |=> state_q == sbus_pkg::StRun && last_o)
    else $error("last word did not end the unpack");

  a_all_bits_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_go && chan_q == sbus_pkg::LastChan |=>
      cnt_q == '0 && rd_addr_q == sbus_pkg::PayloadAw'(sbus_pkg::PayloadLen))
    else $error("unpack ended with payload bits left over");

endmodule

// File: tb/sv/tb_sbus_frame_decoder.sv
`timescale 1ns / 1ps
// Self-checking testbench for sbus_frame_decoder: streams directed and random SBUS
// frames, predicts the sixteen channel words of each good frame and checks them.
// Depends on sbus_pkg and the sbus_frame_decoder RTL.
module tb_sbus_frame_decoder;

  localparam int unsigned IdleLimit  = 4000;
  localparam int unsigned DrainWait  = 120;
  localparam int unsigned RandBytes  = 110;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    logic [sbus_pkg::ChanW-1:0]    chan;
    logic [sbus_pkg::ChanBits-1:0] value;
    logic                          last;
  } chan_word_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [sbus_pkg::ByteW-1:0] rx_byte = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [3:0]                 channel;
  logic [10:0]                position;
  logic                       last;

  logic [sbus_pkg::ByteW-1:0] byte_q[$];
  chan_word_t                 pending_channels[$];

  logic [sbus_pkg::PosW-1:0]  frame_pos;
  logic [sbus_pkg::ByteW-1:0] payload_mem[sbus_pkg::PayloadLen];

  int unsigned tx_wait;
  int unsigned rx_wait;
  int unsigned tx_burst;
  int unsigned rx_burst;
  int unsigned idle_cycles;
  int unsigned mismatches;
  bit          failed;

  sbus_frame_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .rx_byte_i  (rx_byte),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .channel_o  (channel),
    .position_o (position),
    .last_o     (last)
  );

  always #2 clk_i = ~clk_i;

  function automatic int unsigned pick_wait(inout int unsigned burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  task automatic queue_frame(input logic [sbus_pkg::ByteW-1:0] tail);
    byte_q.push_back(sbus_pkg::StartByte);
    for (int i = 0; i < sbus_pkg::PayloadLen + 1; i++) begin
      byte_q.push_back(sbus_pkg::ByteW'($urandom_range(0, 255)));
    end
    byte_q.push_back(tail);
  endtask

  task automatic queue_noise(input int unsigned count);
    logic [sbus_pkg::ByteW-1:0] b;
    for (int i = 0; i < count; i++) begin
      b = sbus_pkg::ByteW'($urandom_range(0, 255));
      if (b == sbus_pkg::StartByte) begin
        b = ~b;
      end
      byte_q.push_back(b);
    end
  endtask

  task automatic absorb_byte(input logic [sbus_pkg::ByteW-1:0] b);
    logic [sbus_pkg::PayloadLen*sbus_pkg::ByteW-1:0] bits;
    chan_word_t                                      w;
    if (frame_pos == sbus_pkg::PosHunt || frame_pos >= sbus_pkg::PosLimit) begin
      frame_pos = (b == sbus_pkg::StartByte) ? sbus_pkg::PosFirst : sbus_pkg::PosHunt;
    end else if (frame_pos <= sbus_pkg::PosLastPayload) begin
      payload_mem[sbus_pkg::PayloadAw'(frame_pos - sbus_pkg::PosFirst)] = b;
      frame_pos = frame_pos + 1'b1;
    end else if (frame_pos == sbus_pkg::PosFlags) begin
      frame_pos = sbus_pkg::PosEnd;
    end else begin
      frame_pos = sbus_pkg::PosHunt;
      if (b == sbus_pkg::EndByte) begin
        for (int i = 0; i < sbus_pkg::PayloadLen; i++) begin
          bits[i*sbus_pkg::ByteW +: sbus_pkg::ByteW] = payload_mem[i];
        end
        for (int k = 0; k < 16; k++) begin
          w.chan  = sbus_pkg::ChanW'(k);
          w.value = bits[k*sbus_pkg::ChanBits +: sbus_pkg::ChanBits];
          w.last  = (sbus_pkg::ChanW'(k) == sbus_pkg::LastChan);
          pending_channels.push_back(w);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      tx_wait   = 0;
      tx_burst  = 0;
      frame_pos = sbus_pkg::PosHunt;
    end else begin
      if (in_valid && in_ready) begin
        absorb_byte(rx_byte);
        tx_wait = pick_wait(tx_burst);
      end
      if (!in_valid || in_ready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_valid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          rx_byte  <= byte_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    chan_word_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      rx_wait   = 0;
      rx_burst  = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_channels.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("unexpected word: channel %0d position %0d last %0b",
                     channel, position, last);
          end
        end else begin
          want = pending_channels.pop_front();
          if (channel !== want.chan || position !== want.value || last !== want.last) begin
            mismatches++;
            if (mismatches <= MaxReports) begin
              $display("mismatch: expected channel %0d position %0d last %0b, got %0d %0d %0b",
                       want.chan, want.value, want.last, channel, position, last);
            end
          end
        end
        rx_wait = pick_wait(rx_burst);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int unsigned mark;
    int unsigned kind;
    idle_cycles = 0;
    mismatches  = 0;
    failed      = 1'b0;

    // Junk while hunting, then a frame with all-ones and all-zero channels and
    // start-byte values in the payload and flags.
    byte_q.push_back(8'hFF);
    byte_q.push_back(8'h00);
    byte_q.push_back(sbus_pkg::StartByte);
    for (int i = 0; i < sbus_pkg::PayloadLen; i++) begin
      byte_q.push_back(i < 11 ? 8'hFF : (i == 11 ? sbus_pkg::StartByte : 8'h00));
    end
    byte_q.push_back(sbus_pkg::StartByte);
    byte_q.push_back(sbus_pkg::EndByte);
    // A bad end byte equal to the start byte must not open a frame.
    queue_frame(sbus_pkg::StartByte);
    queue_noise(sbus_pkg::PayloadLen + 1);
    byte_q.push_back(sbus_pkg::EndByte);

    mark = byte_q.size();
    while (byte_q.size() < mark + RandBytes) begin
      kind = $urandom_range(0, 19);
      if (kind < 14) begin
        queue_frame(sbus_pkg::EndByte);
      end else if (kind < 17) begin
        queue_frame(kind == 16 ? sbus_pkg::StartByte
                               : sbus_pkg::ByteW'($urandom_range(1, 255)));
      end else begin
        for (int i = $urandom_range(1, 5); i > 0; i--) begin
          byte_q.push_back(sbus_pkg::ByteW'($urandom_range(0, 255)));
        end
      end
    end
    queue_frame(sbus_pkg::EndByte);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (byte_q.size() > 0 || in_valid || pending_channels.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (DrainWait) @(posedge clk_i);

    if (pending_channels.size() > 0) begin
      failed = 1'b1;
    end
    if (!failed && mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/sbus_pkg.sv
sv/sbus_ram.sv
sv/sbus_frame_decoder.sv
tb/sv/tb_sbus_frame_decoder.sv
